FILE: rtl/cdct_pkg.sv
package cdct_pkg;

  localparam int SLOTS_DEF = 16;
  localparam int TICKS_DEF = 10;
  localparam int SLOT_W = 4;
  localparam int SAMPLE_W = 32;
  localparam int BW_W = 32;
  localparam int SUM_W = 40;
  localparam int SHARE_W = 17;
  localparam int RATIO_W = 17;
  localparam logic [SHARE_W-1:0] ONE_Q16 = 17'd65536;
  localparam logic [RATIO_W-1:0] RATIO_MIN = 17'd49152;
  localparam logic [RATIO_W-1:0] RATIO_MAX = 17'd81920;
  localparam logic [BW_W-1:0] BW_RESET = 32'd1048576;

  typedef enum logic [2:0] {
    ACT_TICK = 3'd0,
    ACT_SAMPLE = 3'd1,
    ACT_REBAL = 3'd2,
    ACT_OPEN = 3'd3,
    ACT_CLOSE = 3'd4
  } action_t;

  localparam logic CMD_RESUME = 1'b0;
  localparam logic CMD_SUSPEND = 1'b1;

  typedef struct packed {
    logic [2:0] action;
    logic [SLOT_W-1:0] slot;
    logic [SAMPLE_W-1:0] throughput_sample;
  } in_item_t;

  typedef struct packed {
    logic [SLOT_W-1:0] slot_out;
    logic command;
    logic [SHARE_W-1:0] share_out;
    logic last;
  } out_item_t;

endpackage

FILE: rtl/cdct_ram.sv
module cdct_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // one write port, registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: rtl/cdct_div.sv
module cdct_div
  import cdct_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  input  logic [BW_W-1:0]      max_bw,
  input  logic [SUM_W-1:0]     sum,
  output logic                 done,
  output logic [RATIO_W-1:0]   ratio
);

  // restoring divide of max_bw<<16 by sum+1, one quotient bit per cycle
  localparam int NUM_W = BW_W + 16;
  localparam int DEN_W = SUM_W + 1;
  localparam int CNT_W = $clog2(NUM_W + 1);

  logic [NUM_W-1:0] num;
  logic [DEN_W-1:0] den;
  logic [DEN_W-1:0] rem;
  logic [NUM_W-1:0] quo;
  logic [CNT_W-1:0] cnt;
  logic             busy;
  logic [DEN_W:0]   trial;
  logic [DEN_W:0]   diff;

  assign trial = {rem, num[NUM_W-1]};
  assign diff = trial - {1'b0, den};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        num <= {max_bw, 16'd0};
        den <= {1'b0, sum} + DEN_W'(1);
        rem <= '0;
        quo <= '0;
        cnt <= CNT_W'(NUM_W);
      end else if (busy) begin
        num <= {num[NUM_W-2:0], 1'b0};
        if (!diff[DEN_W]) begin
          rem <= diff[DEN_W-1:0];
          quo <= {quo[NUM_W-2:0], 1'b1};
        end else begin
          rem <= trial[DEN_W-1:0];
          quo <= {quo[NUM_W-2:0], 1'b0};
        end
        cnt <= cnt - CNT_W'(1);
        if (cnt == CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // clamp to 0.75..1.25
  always_comb begin
    priority if (quo < NUM_W'(RATIO_MIN)) begin
      ratio = RATIO_MIN;
    end else if (quo > NUM_W'(RATIO_MAX)) begin
      ratio = RATIO_MAX;
    end else begin
      ratio = quo[RATIO_W-1:0];
    end
  end

endmodule

FILE: rtl/chunk_duty_cycle_throttle_top.sv
// channel | dir | handshake           | payload
// in      | in  | in_valid/in_stall   | in_item_t (action, slot, throughput_sample)
// out     | out | out_valid/out_stall | out_item_t (slot_out, command, share_out, last)
// cfg     | in  | cfg_we              | cfg_data = max_bandwidth
// one item at a time; open, close and sample are done in idle without leaving it
// a tick walks all SLOTS entries through the slot ram, a read and a process state a slot, plus stalls
// a rebalance runs a bit-serial divide, then a read and a process state a slot
// sync reset clears counter, sum, active bits and register; ram content is left as is
// out_stall holds the tick walk; the input is stalled until the item is finished
module chunk_duty_cycle_throttle_top
  import cdct_pkg::*;
#(
  parameter int SLOTS = SLOTS_DEF,
  parameter int TICKS = TICKS_DEF
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_item_t  in_item,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_item,
  input  logic      cfg_we,
  input  logic [BW_W-1:0] cfg_data
);

  localparam int AW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int TW = $clog2(TICKS);
  localparam int ENT_W = TW + SHARE_W;
  localparam logic [TW-1:0] LIM_MAX = TW'(TICKS - 1);

  typedef enum logic [2:0] {
    S_IDLE, S_DIV, S_READ, S_PROC, S_DONE
  } state_t;

  state_t            state;
  logic [BW_W-1:0]   max_bw;
  logic [SUM_W-1:0]  sum;
  logic [TW-1:0]     tcount;
  logic [SLOTS-1:0]  active;
  logic              is_tick;
  logic [AW:0]       idx;
  logic [RATIO_W-1:0] ratio_r;
  logic              pend_v;
  out_item_t         pend;

  // slot ram: {limit, share}
  logic              ram_we;
  logic [AW-1:0]     ram_waddr;
  logic [ENT_W-1:0]  ram_wdata;
  logic [AW-1:0]     ram_raddr;
  logic [ENT_W-1:0]  ram_rdata;
  logic [TW-1:0]     rd_lim;
  logic [SHARE_W-1:0] rd_share;

  logic              div_start;
  logic              div_done;
  logic [RATIO_W-1:0] div_ratio;

  logic [TW+RATIO_W-1:0]      lim_prod;
  logic [SHARE_W+RATIO_W-1:0] sh_prod;
  logic [TW+RATIO_W-17:0]     lim_q;
  logic [SHARE_W+RATIO_W-17:0] sh_q;
  logic [TW-1:0]     lim_new;
  logic [SHARE_W-1:0] sh_new;
  logic [TW-1:0]     tcount_next;
  logic [SUM_W:0]    sum_add;
  logic              out_free;
  logic              last_slot;
  logic              hit;
  logic              out_load;

  cdct_ram #(.WIDTH(ENT_W), .DEPTH(SLOTS)) u_ram (
    .clk(clk), .we(ram_we), .waddr(ram_waddr), .wdata(ram_wdata),
    .raddr(ram_raddr), .rdata(ram_rdata)
  );

  cdct_div u_div (
    .clk(clk), .rst(rst), .start(div_start), .max_bw(max_bw), .sum(sum),
    .done(div_done), .ratio(div_ratio)
  );

  assign rd_lim = ram_rdata[ENT_W-1:SHARE_W];
  assign rd_share = ram_rdata[SHARE_W-1:0];
  assign in_stall = (state != S_IDLE);
  assign out_free = !out_valid || !out_stall;
  assign ram_raddr = idx[AW-1:0];
  assign last_slot = (idx == (AW+1)'(SLOTS - 1));
  assign div_start = (state == S_IDLE) && in_valid
                     && (in_item.action == ACT_REBAL);
  assign tcount_next = (tcount == LIM_MAX) ? '0 : tcount + TW'(1);
  assign sum_add = {1'b0, sum} + (SUM_W+1)'(in_item.throughput_sample);

  // command found for the slot under the tick walk
  assign hit = active[idx[AW-1:0]] && (tcount == '0 || tcount == rd_lim);
  // a held command moves to the output register this cycle
  assign out_load = out_free && pend_v
                    && ((state == S_PROC && is_tick && hit) || state == S_DONE);

  // rebalance scaling of the read entry
  assign lim_prod = rd_lim * ratio_r;
  assign sh_prod = rd_share * ratio_r;
  assign lim_q = lim_prod[TW+RATIO_W-1:16];
  assign sh_q = sh_prod[SHARE_W+RATIO_W-1:16];
  always_comb begin
    priority if (lim_q > (TW+RATIO_W-16)'(LIM_MAX)) begin
      lim_new = LIM_MAX;
    end else if (lim_q == '0) begin
      lim_new = TW'(1);
    end else begin
      lim_new = lim_q[TW-1:0];
    end
    if (sh_q > (SHARE_W+RATIO_W-16)'(ONE_Q16)) begin
      sh_new = ONE_Q16;
    end else begin
      sh_new = sh_q[SHARE_W-1:0];
    end
  end

  // write port: open in idle, scaled entry in the rebalance walk
  always_comb begin
    ram_we = 1'b0;
    ram_waddr = in_item.slot[AW-1:0];
    ram_wdata = {LIM_MAX, ONE_Q16};
    if (state == S_IDLE) begin
      ram_we = in_valid && (in_item.action == ACT_OPEN)
               && ((AW+1)'(in_item.slot) < (AW+1)'(SLOTS));
    end else if (state == S_PROC && !is_tick) begin
      ram_we = active[idx[AW-1:0]];
      ram_waddr = idx[AW-1:0];
      ram_wdata = {lim_new, sh_new};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      max_bw <= BW_RESET;
      sum <= '0;
      tcount <= '0;
      active <= '0;
      out_valid <= 1'b0;
      pend_v <= 1'b0;
      idx <= '0;
      is_tick <= 1'b0;
    end else begin
      if (cfg_we) begin
        max_bw <= cfg_data;
      end
      if (out_valid && !out_stall && !out_load) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          idx <= '0;
          if (in_valid) begin
            priority case (in_item.action)
              ACT_TICK: begin
                tcount <= tcount_next;
                is_tick <= 1'b1;
                pend_v <= 1'b0;
                state <= S_READ;
              end
              ACT_SAMPLE: begin
                sum <= sum_add[SUM_W] ? '1 : sum_add[SUM_W-1:0];
              end
              ACT_REBAL: begin
                is_tick <= 1'b0;
                state <= S_DIV;
              end
              ACT_OPEN: begin
                if ((AW+1)'(in_item.slot) < (AW+1)'(SLOTS)) begin
                  active[in_item.slot[AW-1:0]] <= 1'b1;
                end
              end
              ACT_CLOSE: begin
                if ((AW+1)'(in_item.slot) < (AW+1)'(SLOTS)) begin
                  active[in_item.slot[AW-1:0]] <= 1'b0;
                end
              end
              default: begin
              end
            endcase
          end
        end
        S_DIV: begin
          if (div_done) begin
            ratio_r <= div_ratio;
            state <= S_READ;
          end
        end
        S_READ: begin
          state <= S_PROC;
        end
        S_PROC: begin
          if (!is_tick) begin
            if (last_slot) begin
              sum <= '0;
              state <= S_IDLE;
            end else begin
              idx <= idx + (AW+1)'(1);
              state <= S_READ;
            end
          end else if (out_free) begin
            // hold one found command back so last can be set on the final one
            if (hit) begin
              if (pend_v) begin
                out_valid <= 1'b1;
                out_item <= pend;
              end
              pend_v <= 1'b1;
              pend.slot_out <= SLOT_W'(idx);
              pend.command <= (tcount == '0) ? CMD_RESUME : CMD_SUSPEND;
              pend.share_out <= (tcount == '0) ? '0 : rd_share;
              pend.last <= 1'b0;
            end
            if (last_slot) begin
              state <= S_DONE;
            end else begin
              idx <= idx + (AW+1)'(1);
              state <= S_READ;
            end
          end
        end
        S_DONE: begin
          if (out_free) begin
            if (pend_v) begin
              out_valid <= 1'b1;
              out_item <= '{slot_out: pend.slot_out, command: pend.command,
                            share_out: pend.share_out, last: 1'b1};
            end
            pend_v <= 1'b0;
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // a result only appears while a tick walk finishes its slots
  assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> ($past(state) == S_PROC || $past(state) == S_DONE))
    else $error("result outside tick walk");
  // input is taken only in idle
  assert property (@(posedge clk) disable iff (rst)
    (state != S_IDLE) |-> in_stall)
    else $error("input accepted while busy");
  // a stalled result holds
  assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> (out_valid && $stable(out_item)))
    else $error("stalled result changed");
  // a rebalance clears the sum on its way out
  assert property (@(posedge clk) disable iff (rst)
    (state == S_PROC && !is_tick && last_slot) |=> (sum == '0))
    else $error("sum not cleared");

endmodule
